/* hdl/ewga_pkg.sv */
// ----------------------------------------------------------------------------
// ewga_pkg
// Shared types and constants of the expert weight gather address generator.
// ----------------------------------------------------------------------------
package ewga_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_K_TILE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_K_TILES      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K_TILES_PER_EXPERT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_N_TILES_PER_EXPERT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_PER_EXPERT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_COLUMNS       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTED_EXPERTS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GATHER_MODE        = 3'd7;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_COLUMN = 1'b1;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [1:0] MODE_KTILE  = 2'd0;
    localparam logic [1:0] MODE_ZERO   = 2'd1;
    localparam logic [1:0] MODE_COLUMN = 2'd2;

    typedef struct packed {
        logic        op;
        logic [3:0]  slot_index;
        logic [31:0] expert_number;
        logic [15:0] column;
        logic        first_column;
        logic        last_column;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] page_index;
        logic [3:0]  buffer_slot;
        logic        end_of_run;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic div_start;
        logic div_latch;
        logic rd;
        logic mul;
        logic emit_read;
        logic emit_prev;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic has_reads;
        logic more_reads;
        logic need_prev;
        logic need_last;
    } status_t;

endpackage

/* hdl/ewga_div.sv */
// ----------------------------------------------------------------------------
// ewga_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ewga_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ewga_pkg::DIV_W-1:0] dividend,
    input  logic [ewga_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [ewga_pkg::DIV_W-1:0] quotient,
    output logic [ewga_pkg::DIV_W-1:0] remainder
);
    import ewga_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic [CW-1:0]    count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] divisor_reg;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W+1:0] diff;
    logic [DIV_W-1:0] quo_next;
    logic [DIV_W-1:0] rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, divisor_reg};
        rem_next  = diff[DIV_W+1] ? rem_shift[DIV_W-1:0] : diff[DIV_W-1:0];
        quo_next  = {quo_reg[DIV_W-2:0], ~diff[DIV_W+1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CW'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/ewga_datapath.sv */
// ----------------------------------------------------------------------------
// ewga_datapath
// Configuration, expert table, slot tracking, page arithmetic and output
// register.
// ----------------------------------------------------------------------------
module ewga_datapath #(
    parameter int MAX_K_TILES  = 16,
    parameter int TABLE_DEPTH  = 16,
    parameter int EXPERT_COUNT = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ewga_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ewga_pkg::CFG_DATA_W-1:0] cfg_data,
    input  ewga_pkg::in_item_t              in_data,
    input  ewga_pkg::cmd_t                  cmd,
    output ewga_pkg::status_t               status,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ewga_pkg::out_item_t             out_data
);
    import ewga_pkg::*;

    localparam int RW = $clog2(MAX_K_TILES + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = (EXPERT_COUNT > 1) ? $clog2(EXPERT_COUNT) : 1;

    logic [7:0]  first_k_tile_reg;
    logic [7:0]  total_k_tiles_reg;
    logic [7:0]  k_tiles_per_expert_reg;
    logic [15:0] n_tiles_per_expert_reg;
    logic [23:0] tiles_per_expert_reg;
    logic [15:0] half_columns_reg;
    logic [4:0]  selected_experts_reg;
    logic [1:0]  gather_mode_reg;

    logic [31:0] table_mem [TABLE_DEPTH];

    logic [15:0] column_reg;
    logic        first_reg;
    logic        last_reg;
    logic [RW-1:0] reads_reg;
    logic [RW-1:0] j_reg;
    logic [20:0] split_reg;
    logic        below_reg;
    logic [15:0] slot_reg;
    logic        slot_none_reg;
    logic [7:0]  kte_reg;
    logic [16:0] ne_reg;
    logic [31:0] rd_data_reg;
    logic        slot_ok_reg;
    logic [31:0] prod_e_reg;
    logic [23:0] prod_k_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [8:0]       k_diff;
    logic [7:0]       reads_full;
    logic [20:0]      split_next;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
    logic             div_done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
    logic [EW-1:0]    expert;
    logic [EW+23:0]   e_full;
    logic [RW:0]      j_inc;
    logic             emit;
    logic             kte_wrap;
    logic [15:0]      slot_first;
    logic             slot_none_first;
    logic [7:0]       kte_first;
    logic [16:0]      ne_first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_k_tile_reg       <= 8'd0;
            total_k_tiles_reg      <= 8'd0;
            k_tiles_per_expert_reg <= 8'd1;
            n_tiles_per_expert_reg <= 16'd0;
            tiles_per_expert_reg   <= 24'd0;
            half_columns_reg       <= 16'd1;
            selected_experts_reg   <= 5'd0;
            gather_mode_reg        <= MODE_KTILE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FIRST_K_TILE:       first_k_tile_reg       <= cfg_data[7:0];
                CFG_TOTAL_K_TILES:      total_k_tiles_reg      <= cfg_data[7:0];
                CFG_K_TILES_PER_EXPERT: k_tiles_per_expert_reg <= cfg_data[7:0];
                CFG_N_TILES_PER_EXPERT: n_tiles_per_expert_reg <= cfg_data[15:0];
                CFG_TILES_PER_EXPERT:   tiles_per_expert_reg   <= cfg_data[23:0];
                CFG_HALF_COLUMNS:       half_columns_reg       <= cfg_data[15:0];
                CFG_SELECTED_EXPERTS:   selected_experts_reg   <= cfg_data[4:0];
                CFG_GATHER_MODE:        gather_mode_reg        <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && in_data.op == OP_LOAD
            && 9'(in_data.slot_index) < 9'(TABLE_DEPTH))
        begin
            table_mem[AW'(in_data.slot_index)] <= in_data.expert_number;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= table_mem[AW'(slot_reg)];
        end
    end

    always_comb
    begin
        k_diff     = {1'b0, total_k_tiles_reg} - {1'b0, first_k_tile_reg};
        if (total_k_tiles_reg <= first_k_tile_reg)
            reads_full = 8'd0;
        else if (k_diff[7:0] > 8'(MAX_K_TILES))
            reads_full = 8'(MAX_K_TILES);
        else
            reads_full = k_diff[7:0];
        split_next = 21'(selected_experts_reg) * 21'(half_columns_reg);
        if (gather_mode_reg == MODE_KTILE)
        begin
            dividend = 16'(first_k_tile_reg);
            divisor  = 16'(k_tiles_per_expert_reg);
        end
        else
        begin
            dividend = below_reg ? column_reg : 16'(21'(column_reg) - split_reg);
            divisor  = half_columns_reg;
        end
        if (slot_ok_reg && {1'b0, rd_data_reg} < 33'(EXPERT_COUNT))
            expert = rd_data_reg[EW-1:0];
        else
            expert = '0;
        e_full   = expert * tiles_per_expert_reg;
        j_inc    = {1'b0, j_reg} + 1'b1;
        emit     = cmd.emit_read | cmd.emit_prev | cmd.emit_last;
        kte_wrap = gather_mode_reg == MODE_KTILE && k_tiles_per_expert_reg != 8'd0
                   && {1'b0, kte_reg} + 9'd1 == {1'b0, k_tiles_per_expert_reg};
    end

    always_comb
    begin
        slot_none_first = 1'b0;
        slot_first      = 16'd0;
        kte_first       = first_k_tile_reg;
        ne_first        = 17'(column_reg);
        case (gather_mode_reg)
            MODE_KTILE:
            begin
                if (k_tiles_per_expert_reg == 8'd0)
                    slot_none_first = 1'b1;
                else
                begin
                    slot_first = quotient;
                    kte_first  = remainder[7:0];
                end
            end
            MODE_COLUMN:
            begin
                if (half_columns_reg == 16'd0)
                    slot_none_first = 1'b1;
                else
                begin
                    slot_first = quotient;
                    ne_first   = below_reg ? 17'(remainder)
                                           : 17'(half_columns_reg) + 17'(remainder);
                end
            end
            default: ;
        endcase
    end

    ewga_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            column_reg <= in_data.column;
            first_reg  <= in_data.first_column;
            last_reg   <= in_data.last_column;
        end
        if (cmd.setup)
        begin
            reads_reg <= RW'(reads_full);
            split_reg <= split_next;
            below_reg <= 21'(column_reg) < split_next;
            j_reg     <= '0;
        end
        if (cmd.div_latch)
        begin
            slot_none_reg <= slot_none_first;
            slot_reg      <= slot_first;
            kte_reg       <= kte_first;
            ne_reg        <= ne_first;
        end
        if (cmd.rd)
        begin
            slot_ok_reg <= !slot_none_reg && 17'(slot_reg) < 17'(TABLE_DEPTH);
        end
        if (cmd.mul)
        begin
            prod_e_reg <= 32'(e_full);
            prod_k_reg <= kte_reg * n_tiles_per_expert_reg;
        end
        if (cmd.emit_read)
        begin
            j_reg <= RW'(j_inc);
            if (kte_wrap)
            begin
                kte_reg  <= 8'd0;
                slot_reg <= slot_reg + 16'd1;
            end
            else
                kte_reg <= kte_reg + 8'd1;
        end
        if (cmd.emit_read)
        begin
            out_reg.kind        <= KIND_READ;
            out_reg.page_index  <= prod_e_reg + 32'(prod_k_reg) + 32'(ne_reg);
            out_reg.buffer_slot <= 4'(j_reg);
            out_reg.end_of_run  <= !status.more_reads && first_reg && !last_reg;
        end
        else if (cmd.emit_prev)
        begin
            out_reg.kind        <= KIND_WRITE;
            out_reg.page_index  <= 32'(column_reg) - 32'd1;
            out_reg.buffer_slot <= 4'd0;
            out_reg.end_of_run  <= !last_reg;
        end
        else if (cmd.emit_last)
        begin
            out_reg.kind        <= KIND_WRITE;
            out_reg.page_index  <= 32'(column_reg);
            out_reg.buffer_slot <= 4'd0;
            out_reg.end_of_run  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        status.div_done   = div_done;
        status.out_free   = !out_valid_reg || !out_stall;
        status.has_reads  = reads_reg != '0;
        status.more_reads = j_inc < {1'b0, reads_reg};
        status.need_prev  = !first_reg;
        status.need_last  = last_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hdl/ewga_ctrl.sv */
// ----------------------------------------------------------------------------
// ewga_ctrl
// Sequencer for one transaction: setup, divide, reads, output writes.
// ----------------------------------------------------------------------------
module ewga_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_stall,
    input  ewga_pkg::status_t status,
    output ewga_pkg::cmd_t    cmd
);
    import ewga_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SETUP = 9'b000000010,
        ST_START = 9'b000000100,
        ST_DIV   = 9'b000001000,
        ST_RD    = 9'b000010000,
        ST_MUL   = 9'b000100000,
        ST_EMIT  = 9'b001000000,
        ST_WPREV = 9'b010000000,
        ST_WLAST = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_reads;

    always_comb
    begin
        if (status.need_prev)
            after_reads = ST_WPREV;
        else if (status.need_last)
            after_reads = ST_WLAST;
        else
            after_reads = ST_IDLE;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid && in_op == OP_COLUMN)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    state_next    = status.has_reads ? ST_RD : after_reads;
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_read = 1'b1;
                    state_next    = status.more_reads ? ST_RD : after_reads;
                end
            end
            ST_WPREV:
            begin
                if (status.out_free)
                begin
                    cmd.emit_prev = 1'b1;
                    state_next    = status.need_last ? ST_WLAST : ST_IDLE;
                end
            end
            ST_WLAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* hdl/expert_weight_gather_address_gen_core.sv */
// ----------------------------------------------------------------------------
// expert_weight_gather_address_gen_core
// Gathered mixture-of-experts page index generator: weight-page reads per
// column transaction, output-page writes one column behind, plus the current
// column's page on the last column.
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall   | ewga_pkg::in_item_t
//   out     | output    | out_valid / out_stall | ewga_pkg::out_item_t
//   cfg     | input     | cfg_wr_en             | cfg_index, cfg_data
//
// A load transaction writes the expert table and leaves the sequencer idle.
// A column transaction runs the serial divider that finds the first slot,
// then a table read, a multiply and an add per read, then the writes.
// Reset clears the state machine, configuration and output valid.
// A stalled output holds the sequencer; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module expert_weight_gather_address_gen_core #(
    parameter int MAX_K_TILES  = 16,
    parameter int TABLE_DEPTH  = 16,
    parameter int EXPERT_COUNT = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ewga_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ewga_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ewga_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ewga_pkg::out_item_t             out_data
);
    import ewga_pkg::*;

    cmd_t    cmd;
    status_t status;

    ewga_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.op),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ewga_datapath #(
        .MAX_K_TILES  (MAX_K_TILES),
        .TABLE_DEPTH  (TABLE_DEPTH),
        .EXPERT_COUNT (EXPERT_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* hdl/ewga_checker.sv */
// ----------------------------------------------------------------------------
// ewga_checker
// Port-level checks of the address generator, bound to the top level.
// ----------------------------------------------------------------------------
module ewga_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input ewga_pkg::in_item_t              in_data,
    input logic                            out_valid,
    input logic                            out_stall,
    input ewga_pkg::out_item_t             out_data
);
    import ewga_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

    a_load_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.op == OP_LOAD |=> !in_stall)
        else $error("load transaction blocked the input");

    a_column_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.op == OP_COLUMN |=> in_stall)
        else $error("column transaction did not hold the input");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a column in flight");

    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_WRITE |-> out_data.buffer_slot == 4'd0)
        else $error("write transaction with nonzero buffer slot");

endmodule

bind expert_weight_gather_address_gen_core ewga_checker u_ewga_checker (.*);
